### rtl/core/assert_macros.svh
// Assertion macros for the RTL files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, disabled while rst_n is low
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check on clk that also holds during reset
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/thtf_pkg.sv
// Shared types and constants of the thermocouple temperature filter
`default_nettype none

package thtf_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int CJ_W       = 8;
  localparam int TEMP_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int SPAN_W     = 7;
  localparam int BASE_W     = 9;
  localparam int CAL_NUM_W  = 19;
  localparam int CAL_SUM_W  = 20;
  localparam int DEN_W      = 12;

  localparam int WINDOW_LEN_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ADC_100C    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_200C    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_300C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_420C    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLITCH_LIMIT = 3'd4;

  localparam logic [SAMPLE_W-1:0] ADC_100C_RST    = 12'd1000;
  localparam logic [SAMPLE_W-1:0] ADC_200C_RST    = 12'd2000;
  localparam logic [SAMPLE_W-1:0] ADC_300C_RST    = 12'd3000;
  localparam logic [SAMPLE_W-1:0] ADC_420C_RST    = 12'd4000;
  localparam logic [SAMPLE_W-1:0] GLITCH_LIMIT_RST = 12'd4060;

  localparam logic [SPAN_W-1:0] SPAN_LOW = 7'd100;
  localparam logic [SPAN_W-1:0] SPAN_TOP = 7'd120;

  localparam logic [BASE_W-1:0] BASE_0C   = 9'd0;
  localparam logic [BASE_W-1:0] BASE_100C = 9'd100;
  localparam logic [BASE_W-1:0] BASE_200C = 9'd200;
  localparam logic [BASE_W-1:0] BASE_300C = 9'd300;

  localparam logic [TEMP_W-1:0] TEMP_SAT = 16'hFFFF;

  typedef struct packed {
    logic rd;
    logic upd;
  } win_ctl_t;

endpackage

`default_nettype wire

### rtl/core/thtf_div.sv
// Shared restoring divider, one quotient bit per cycle
`default_nettype none

module thtf_div #(
  parameter int NUM_W = thtf_pkg::CAL_NUM_W,
  parameter int DEN_W = thtf_pkg::DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             borrow;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign borrow  = diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= borrow ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ~borrow};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

### rtl/core/thtf_win.sv
// Moving-average window store with running sum
`default_nettype none

module thtf_win #(
  parameter int WINDOW_LEN = thtf_pkg::WINDOW_LEN_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  thtf_pkg::win_ctl_t                                 ctl,
  input  logic [thtf_pkg::TEMP_W-1:0]                        temp,
  output logic [thtf_pkg::TEMP_W+$clog2(WINDOW_LEN)-1:0]     sum
);

  localparam int PTR_W = $clog2(WINDOW_LEN);
  localparam int SUM_W = thtf_pkg::TEMP_W + PTR_W;

  logic [thtf_pkg::TEMP_W-1:0] mem [WINDOW_LEN];
  logic [thtf_pkg::TEMP_W-1:0] rd_q_r;
  logic                        vld_q_r;
  logic [WINDOW_LEN-1:0]       valid_r;
  logic [PTR_W-1:0]            ptr_r;
  logic [SUM_W-1:0]            sum_r;
  logic [thtf_pkg::TEMP_W-1:0] old_temp;

  assign old_temp = vld_q_r ? rd_q_r : '0;

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      mem[ptr_r] <= temp;
    end
    if (ctl.rd) begin
      rd_q_r <= mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_q_r <= 1'b0;
      ptr_r   <= '0;
      sum_r   <= '0;
    end else begin
      if (ctl.rd) begin
        vld_q_r <= valid_r[ptr_r];
      end
      if (ctl.upd) begin
        valid_r[ptr_r] <= 1'b1;
        sum_r          <= sum_r - SUM_W'(old_temp) + SUM_W'(temp);
        ptr_r          <= (ptr_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_r + 1'b1;
      end
    end
  end

  assign sum = sum_r;

endmodule

`default_nettype wire

### rtl/core/thermocouple_piecewise_temp_filter.sv
// Thermocouple filter top: glitch reject, segment calibration, moving average
//
//   channel | ports                                          | handshake
//   --------+------------------------------------------------+-------------------
//   input   | in_raw_sample, in_cold_junction_temp           | in_valid / in_stall
//   result  | out_average_temp, out_sample_rejected          | out_valid / out_stall
//   config  | cfg_index, cfg_data                            | cfg_valid / cfg_ready
//
// A transaction runs through the states SEG, CSTART, CDIV, UPD and OUT before the next acceptance:
// the shared divider gives one quotient bit per cycle for the segment interpolation, and
// a flat top segment skips it. The window mean is a constant reciprocal multiply.
// in_stall is high from acceptance until the result is loaded into the output register;
// a held result stretches the output state while out_stall is high.
// Reset restores the calibration registers and clears the window at once.
`default_nettype none
`include "assert_macros.svh"

module thermocouple_piecewise_temp_filter #(
  parameter int WINDOW_LEN = thtf_pkg::WINDOW_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [thtf_pkg::SAMPLE_W-1:0]    in_raw_sample,
  input  logic [thtf_pkg::CJ_W-1:0]        in_cold_junction_temp,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [thtf_pkg::TEMP_W-1:0]      out_average_temp,
  output logic                             out_sample_rejected,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [thtf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [thtf_pkg::SAMPLE_W-1:0]    cfg_data
);

  localparam int SUM_W   = thtf_pkg::TEMP_W + $clog2(WINDOW_LEN);
  localparam int MEAN_SH = SUM_W + $clog2(WINDOW_LEN);
  localparam int MUL_W   = SUM_W + 1;
  localparam int PROD_W  = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] MEAN_MUL =
    MUL_W'(((64'd1 << MEAN_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_CSTART,
    ST_CDIV,
    ST_UPD,
    ST_OUT
  } state_t;

  state_t                             state_r;
  logic [thtf_pkg::SAMPLE_W-1:0]      adc100_r;
  logic [thtf_pkg::SAMPLE_W-1:0]      adc200_r;
  logic [thtf_pkg::SAMPLE_W-1:0]      adc300_r;
  logic [thtf_pkg::SAMPLE_W-1:0]      adc420_r;
  logic [thtf_pkg::SAMPLE_W-1:0]      glitch_r;
  logic [thtf_pkg::SAMPLE_W-1:0]      last_good_r;
  logic [thtf_pkg::SAMPLE_W-1:0]      sample_r;
  logic [thtf_pkg::CJ_W-1:0]          cj_r;
  logic                               rej_r;
  logic [thtf_pkg::CAL_NUM_W-1:0]     num_r;
  logic [thtf_pkg::DEN_W-1:0]         den_r;
  logic [thtf_pkg::BASE_W-1:0]        base_r;
  logic                               flat_r;
  logic [thtf_pkg::TEMP_W-1:0]        temp_r;
  logic                               out_valid_r;
  logic [thtf_pkg::TEMP_W-1:0]        out_avg_r;
  logic                               out_rej_r;

  logic                               in_acc;
  logic                               rejected;
  logic [thtf_pkg::SAMPLE_W-1:0]      seg_lo;
  logic [thtf_pkg::SAMPLE_W-1:0]      seg_hi;
  logic [thtf_pkg::BASE_W-1:0]        seg_base;
  logic [thtf_pkg::SPAN_W-1:0]        seg_span;
  logic                               seg_flat;
  logic [thtf_pkg::SAMPLE_W-1:0]      seg_diff;
  logic [thtf_pkg::CAL_NUM_W-1:0]     seg_num;
  logic [thtf_pkg::CAL_NUM_W-1:0]     cal_q;
  logic [thtf_pkg::CAL_SUM_W-1:0]     cal_sum;
  logic [thtf_pkg::TEMP_W-1:0]        cal_temp;
  logic                               div_start;
  logic [thtf_pkg::CAL_NUM_W-1:0]     div_num;
  logic [thtf_pkg::DEN_W-1:0]         div_den;
  logic                               div_done;
  logic [thtf_pkg::CAL_NUM_W-1:0]     div_quot;
  thtf_pkg::win_ctl_t                 win_ctl;
  logic [SUM_W-1:0]                   win_sum;
  logic [PROD_W-1:0]                  mean_prod;
  logic [thtf_pkg::TEMP_W-1:0]        mean;
  logic                               out_fire;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign rejected  = (in_raw_sample >= glitch_r);

  always_comb begin
    seg_flat = 1'b0;
    if (sample_r < adc100_r) begin
      seg_lo   = '0;
      seg_hi   = adc100_r;
      seg_base = thtf_pkg::BASE_0C;
      seg_span = thtf_pkg::SPAN_LOW;
    end else if (sample_r < adc200_r) begin
      seg_lo   = adc100_r;
      seg_hi   = adc200_r;
      seg_base = thtf_pkg::BASE_100C;
      seg_span = thtf_pkg::SPAN_LOW;
    end else if (sample_r < adc300_r) begin
      seg_lo   = adc200_r;
      seg_hi   = adc300_r;
      seg_base = thtf_pkg::BASE_200C;
      seg_span = thtf_pkg::SPAN_LOW;
    end else begin
      seg_lo   = adc300_r;
      seg_hi   = adc420_r;
      seg_base = thtf_pkg::BASE_300C;
      seg_span = thtf_pkg::SPAN_TOP;
      seg_flat = (adc420_r <= adc300_r);
    end
  end

  assign seg_diff = sample_r - seg_lo;
  assign seg_num  = thtf_pkg::CAL_NUM_W'(seg_diff) * thtf_pkg::CAL_NUM_W'(seg_span);

  assign cal_q    = flat_r ? '0 : div_quot;
  assign cal_sum  = thtf_pkg::CAL_SUM_W'(cal_q) + thtf_pkg::CAL_SUM_W'(base_r)
                  + thtf_pkg::CAL_SUM_W'(cj_r);
  assign cal_temp = (cal_sum > thtf_pkg::CAL_SUM_W'(thtf_pkg::TEMP_SAT))
                  ? thtf_pkg::TEMP_SAT : cal_sum[thtf_pkg::TEMP_W-1:0];

  assign div_start = (state_r == ST_CSTART) && !flat_r;
  assign div_num   = num_r;
  assign div_den   = den_r;

  assign mean_prod = PROD_W'(win_sum) * PROD_W'(MEAN_MUL);
  assign mean      = mean_prod[MEAN_SH +: thtf_pkg::TEMP_W];

  assign win_ctl.rd  = (state_r == ST_SEG);
  assign win_ctl.upd = (state_r == ST_UPD);

  assign out_fire = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  thtf_div #(
    .NUM_W (thtf_pkg::CAL_NUM_W),
    .DEN_W (thtf_pkg::DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  thtf_win #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_win (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (win_ctl),
    .temp  (temp_r),
    .sum   (win_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      adc100_r    <= thtf_pkg::ADC_100C_RST;
      adc200_r    <= thtf_pkg::ADC_200C_RST;
      adc300_r    <= thtf_pkg::ADC_300C_RST;
      adc420_r    <= thtf_pkg::ADC_420C_RST;
      glitch_r    <= thtf_pkg::GLITCH_LIMIT_RST;
      last_good_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          thtf_pkg::REG_ADC_100C:     adc100_r <= cfg_data;
          thtf_pkg::REG_ADC_200C:     adc200_r <= cfg_data;
          thtf_pkg::REG_ADC_300C:     adc300_r <= cfg_data;
          thtf_pkg::REG_ADC_420C:     adc420_r <= cfg_data;
          thtf_pkg::REG_GLITCH_LIMIT: glitch_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            sample_r <= rejected ? last_good_r : in_raw_sample;
            if (!rejected) begin
              last_good_r <= in_raw_sample;
            end
            cj_r    <= in_cold_junction_temp;
            rej_r   <= rejected;
            state_r <= ST_SEG;
          end
        end
        ST_SEG: begin
          num_r   <= seg_num;
          den_r   <= seg_hi - seg_lo;
          base_r  <= seg_base;
          flat_r  <= seg_flat;
          state_r <= ST_CSTART;
        end
        ST_CSTART: begin
          if (flat_r) begin
            temp_r  <= cal_temp;
            state_r <= ST_UPD;
          end else begin
            state_r <= ST_CDIV;
          end
        end
        ST_CDIV: begin
          if (div_done) begin
            temp_r  <= cal_temp;
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_fire) begin
            out_valid_r <= 1'b1;
            out_avg_r   <= mean;
            out_rej_r   <= rej_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_average_temp    = out_avg_r;
  assign out_sample_rejected = out_rej_r;

  `ASSERT_CLK(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "accepted transaction did not hold off input")
  `ASSERT_CLK(a_result_from_out_state, $rose(out_valid_r) |-> $past(state_r == ST_OUT), "result loaded outside output state")
  `ASSERT_CLK(a_div_done_expected, div_done |-> (state_r == ST_CDIV), "divider finished with no division pending")

endmodule

`default_nettype wire
